// File: sv/tvc_pkg.sv
// ----------------------------------------------------------------------------
// tvc_pkg
// Shared codes, character constants and keyword tables for the value token
// type classifier.
// ----------------------------------------------------------------------------
package tvc_pkg;

  localparam logic [1:0] TYPE_STRING  = 2'd0;
  localparam logic [1:0] TYPE_BOOLEAN = 2'd1;
  localparam logic [1:0] TYPE_INTEGER = 2'd2;
  localparam logic [1:0] TYPE_DECIMAL = 2'd3;

  localparam int SPECIAL_KINDS = 6;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Order: '-', '+', '.', ',', 'e', 'E'
  localparam logic [7:0] SPECIAL_CHARS [SPECIAL_KINDS] = '{
    CH_MINUS, CH_PLUS, CH_DOT, CH_COMMA, CH_LOW_E, CH_UP_E
  };

  // Character of "true" at a position
  function automatic logic [7:0] true_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h74;
      2'd1:    c = 8'h72;
      2'd2:    c = 8'h75;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  // Character of "false" at a position; positions past the word give 'f'
  function automatic logic [7:0] false_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h66;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h6c;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

// File: sv/token_value_type_classifier.sv
// ----------------------------------------------------------------------------
// token_value_type_classifier
// The final beat of a token is held in the input register; its type is then
// loaded into the result register.
// Throughput: one character per cycle; the input stalls only while a
// finished type waits in the result register and the next final beat is due.
// Reset (rst, synchronous) empties both registers and clears the token state.
// ----------------------------------------------------------------------------
module token_value_type_classifier
  import tvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] character,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] token_type
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_adv;
  logic       out_free;
  logic       accept;
  logic [1:0] token_type_next;

  assign out_free = !out_valid || !out_stall;
  // Non-final beats never need the result register
  assign s1_adv   = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  tvc_track u_track (
    .clk             (clk),
    .rst             (rst),
    .beat            (s1_adv),
    .character       (s1_char),
    .last            (s1_last),
    .token_type_next (token_type_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_char <= character;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last) begin
      token_type <= token_type_next;
    end
  end

`ifndef SYNTHESIS
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> out_valid)
    else $error("final beat did not load a result");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && s1_last && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_middle_no_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |-> !in_stall)
    else $error("non-final beat held the input");
`endif

endmodule

// File: sv/tvc_track.sv
// ----------------------------------------------------------------------------
// tvc_track
// Running per-token state: keyword match flags, alphabet flags and
// saturating special-character counts, with the type decision for the
// final character.
// ----------------------------------------------------------------------------
module tvc_track
  import tvc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  logic [7:0] character,
  input  logic       last,
  output logic [1:0] token_type_next
);

  logic [2:0] char_position;
  logic       true_match;
  logic       false_match;
  logic       all_integer_chars;
  logic       all_decimal_chars;
  logic       digit_seen;
  logic       first_char_ok;
  logic [1:0] special_counts [SPECIAL_KINDS];

  logic [2:0] char_position_next;
  logic       true_match_next;
  logic       false_match_next;
  logic       all_integer_chars_next;
  logic       all_decimal_chars_next;
  logic       digit_seen_next;
  logic       first_char_ok_next;
  logic [1:0] special_counts_next [SPECIAL_KINDS];

  logic digit;
  logic sign;
  logic dec_punct;
  logic repeated;
  logic is_bool;
  logic number;

  always_comb begin
    digit     = character inside {[CH_ZERO:CH_NINE]};
    sign      = character inside {CH_PLUS, CH_MINUS};
    dec_punct = character inside {CH_DOT, CH_COMMA, CH_LOW_E, CH_UP_E};

    true_match_next  = true_match && (char_position < 3'd4) &&
                       (character == true_char(char_position[1:0]));
    false_match_next = false_match && (char_position < 3'd5) &&
                       (character == false_char(char_position));

    all_integer_chars_next = all_integer_chars && (digit || sign);
    all_decimal_chars_next = all_decimal_chars && (digit || sign || dec_punct);
    digit_seen_next        = digit_seen || digit;
    first_char_ok_next     = (char_position == 3'd0) ? (digit || sign) : first_char_ok;

    repeated = 1'b0;
    for (int i = 0; i < SPECIAL_KINDS; i++) begin
      special_counts_next[i] = special_counts[i];
      if (character == SPECIAL_CHARS[i] && special_counts[i] != 2'd3) begin
        special_counts_next[i] = special_counts[i] + 2'd1;
      end
      repeated = repeated | special_counts_next[i][1];
    end

    char_position_next = (char_position != 3'd7) ? char_position + 3'd1 : char_position;

    is_bool = (true_match_next && char_position == 3'd3) ||
              (false_match_next && char_position == 3'd4);
    number  = digit_seen_next && first_char_ok_next && !repeated;

    if (is_bool) begin
      token_type_next = TYPE_BOOLEAN;
    end else if (all_integer_chars_next) begin
      token_type_next = number ? TYPE_INTEGER : TYPE_STRING;
    end else if (all_decimal_chars_next) begin
      token_type_next = number ? TYPE_DECIMAL : TYPE_STRING;
    end else begin
      token_type_next = TYPE_STRING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (beat && last)) begin
      // Clear for the next token
      char_position     <= 3'd0;
      true_match        <= 1'b1;
      false_match       <= 1'b1;
      all_integer_chars <= 1'b1;
      all_decimal_chars <= 1'b1;
      digit_seen        <= 1'b0;
      first_char_ok     <= 1'b0;
      for (int i = 0; i < SPECIAL_KINDS; i++) begin
        special_counts[i] <= 2'd0;
      end
    end else if (beat) begin
      char_position     <= char_position_next;
      true_match        <= true_match_next;
      false_match       <= false_match_next;
      all_integer_chars <= all_integer_chars_next;
      all_decimal_chars <= all_decimal_chars_next;
      digit_seen        <= digit_seen_next;
      first_char_ok     <= first_char_ok_next;
      for (int i = 0; i < SPECIAL_KINDS; i++) begin
        special_counts[i] <= special_counts_next[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_pos_clears: assert property (@(posedge clk) disable iff (rst)
    beat && last |=> char_position == 3'd0 && true_match && false_match)
    else $error("token state not cleared after final beat");

  a_pos_advances: assert property (@(posedge clk) disable iff (rst)
    beat && !last && char_position == 3'd0 |=> char_position == 3'd1)
    else $error("character position did not advance");

  a_int_implies_dec: assert property (@(posedge clk) disable iff (rst)
    all_integer_chars |-> all_decimal_chars)
    else $error("integer alphabet flag set without decimal flag");
`endif

endmodule

// File: tb/sv/tb_token_value_type_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_token_value_type_classifier
// Streams value tokens one character per beat into the classifier and checks
// each token type that comes back against a cycle-free model of the token
// state. Covers keywords, integer and decimal spellings, repeated special
// characters, stray bytes and long tokens, under sender gaps, receiver
// stalls and one long receiver hold that backs up the input.
// ----------------------------------------------------------------------------
module tb_token_value_type_classifier;
  import tvc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam string KW_TRUE  = "true";
  localparam string KW_FALSE = "false";

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [2:0]      pos;
    logic            true_ok;
    logic            false_ok;
    logic            int_alpha;
    logic            dec_alpha;
    logic            has_digit;
    logic            lead_ok;
    logic [5:0][1:0] punct_cnt;
  } token_state_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] character;
  logic       last;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] token_type;

  token_state_t tok;
  logic [1:0]   expected_types[$];
  int           mismatches = 0;
  int           cycle_count = 0;
  int           idle_pct = 0;
  int           stall_pct = 0;
  int           hold_left = 0;

  token_value_type_classifier dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_type (token_type)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("token_value_type_classifier regression: fail");
      $finish;
    end
  end

  function automatic token_state_t fresh_token();
    token_state_t s;
    s = '0;
    s.true_ok   = 1'b1;
    s.false_ok  = 1'b1;
    s.int_alpha = 1'b1;
    s.dec_alpha = 1'b1;
    return s;
  endfunction

  // Advance the token state by one character; returns 1 with the type on the
  // final character, after which the state starts afresh.
  function automatic bit predict_type(input logic [7:0] c, input logic fin,
                                      output logic [1:0] ty);
    logic [2:0] pos;
    logic       digit;
    logic       sign;
    logic       punct;
    logic       keyword;
    logic       repeated;
    logic       number;
    pos   = tok.pos;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    sign  = (c == CH_PLUS) || (c == CH_MINUS);
    punct = (c == CH_DOT) || (c == CH_COMMA) || (c == CH_LOW_E) || (c == CH_UP_E);
    tok.true_ok  = tok.true_ok && (pos < 4) && (c == KW_TRUE[pos[1:0]]);
    tok.false_ok = tok.false_ok && (pos < 5) && (c == KW_FALSE[(pos < 5) ? pos : 0]);
    tok.int_alpha = tok.int_alpha && (digit || sign);
    tok.dec_alpha = tok.dec_alpha && (digit || sign || punct);
    tok.has_digit = tok.has_digit || digit;
    if (pos == 0) tok.lead_ok = digit || sign;
    for (int k = 0; k < SPECIAL_KINDS; k++) begin
      if (c == SPECIAL_CHARS[k] && tok.punct_cnt[k] != 2'd3) tok.punct_cnt[k]++;
    end
    if (tok.pos != 3'd7) tok.pos++;
    ty = TYPE_STRING;
    if (!fin) return 0;
    keyword  = (tok.true_ok && pos == 3) || (tok.false_ok && pos == 4);
    repeated = 1'b0;
    for (int k = 0; k < SPECIAL_KINDS; k++) begin
      if (tok.punct_cnt[k] > 2'd1) repeated = 1'b1;
    end
    number = tok.has_digit && tok.lead_ok && !repeated;
    if (keyword) ty = TYPE_BOOLEAN;
    else if (tok.int_alpha) ty = number ? TYPE_INTEGER : TYPE_STRING;
    else if (tok.dec_alpha) ty = number ? TYPE_DECIMAL : TYPE_STRING;
    tok = fresh_token();
    return 1;
  endfunction

  // Offer one beat, idling beforehand at the current sender rate.
  task automatic send_char(input logic [7:0] c, input logic fin);
    logic [1:0] ty;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    character = c;
    last      = fin;
    do @(posedge clk); while (in_stall);
    if (predict_type(c, fin, ty)) expected_types.push_back(ty);
    @(negedge clk);
  endtask

  task automatic send_bytes(input byte_q_t b);
    for (int i = 0; i < b.size(); i++) send_char(b[i], i == b.size() - 1);
  endtask

  task automatic send_text(input string s);
    byte_q_t b;
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    send_bytes(b);
  endtask

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed numbers and keywords, some broken ones and raw bytes.
  function automatic byte_q_t random_token();
    byte_q_t t;
    string   w;
    int      kind;
    int      n;
    kind = $urandom_range(0, 19);
    if (kind <= 3) begin
      w = $urandom_range(0, 1) ? KW_TRUE : KW_FALSE;
      for (int i = 0; i < w.len(); i++) t.push_back(w[i]);
      if (kind == 3) begin
        case ($urandom_range(0, 2))
          0: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
          1: void'(t.pop_back());
          default: t.push_back(CH_LOW_E);
        endcase
      end
    end else if (kind <= 10) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 7);
      t.push_back(($urandom_range(0, 3) == 0) ? SPECIAL_CHARS[$urandom_range(0, 1)]
                                               : pick_digit());
      for (int i = 1; i < n; i++) begin
        t.push_back(($urandom_range(0, 99) < 85) ? pick_digit()
                                                 : SPECIAL_CHARS[$urandom_range(0, 1)]);
      end
    end else if (kind <= 16) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(2, 8);
      t.push_back(($urandom_range(0, 9) == 0) ? SPECIAL_CHARS[$urandom_range(2, 5)]
                                               : pick_digit());
      for (int i = 1; i < n; i++) begin
        t.push_back(($urandom_range(0, 99) < 78) ? pick_digit()
                                                 : SPECIAL_CHARS[$urandom_range(0, 5)]);
      end
      // spoil the odd decimal with a stray byte
      if (kind == 16) t[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) t.push_back(8'($urandom_range(0, 255)));
    end
    return t;
  endfunction

  // Receiver: long hold when asked, otherwise stall at the current rate.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    logic [1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_types.size() == 0) begin
        $display("%0t: token_type %0d with no token pending, expected none", $time,
                 token_type);
        mismatches++;
      end else begin
        want = expected_types.pop_front();
        if (token_type !== want) begin
          $display("%0t: token_type mismatch, expected %0d, got %0d", $time, want,
                   token_type);
          mismatches++;
        end
      end
    end
  end

  task automatic test_keywords();
    send_text("true");
    send_text("false");
  endtask

  task automatic test_numbers();
    send_text("9");
    send_text("+0");
    send_text("1.e");
    send_text("0,E");
    send_text(".5");
    send_text("-");
  endtask

  task automatic test_odd_bytes();
    send_text("1--");
    send_bytes('{8'h00});
    send_bytes('{8'hff});
  endtask

  task automatic test_random_tokens(input int beats, input int idle, input int stall);
    byte_q_t t;
    int      sent;
    idle_pct  = idle;
    stall_pct = stall;
    sent      = 0;
    while (sent < beats) begin
      t = random_token();
      send_bytes(t);
      sent += t.size();
    end
  endtask

  // Hold the output off for a long stretch while short tokens keep coming.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 150;
    for (int i = 0; i < 20; i++) begin
      if (i % 3 == 0) send_text("42");
      else send_bytes('{pick_digit()});
    end
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    character = 8'h00;
    last      = 1'b0;
    tok       = fresh_token();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_keywords();
    test_numbers();
    test_odd_bytes();
    test_random_tokens(400, 0, 0);
    test_random_tokens(400, 87, 0);
    test_random_tokens(400, 0, 87);
    test_random_tokens(350, 9, 9);
    test_backpressure();
    in_valid = 1'b0;

    while (expected_types.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("token_value_type_classifier regression: pass");
    end else begin
      $display("token_value_type_classifier regression: fail");
    end
    $finish;
  end

endmodule
